// ===== hdl/upr_pkg.sv =====
// Shared types and constants of the ultrasonic ping ranger.
// Used by upr_cfg_regs, upr_core and ultrasonic_ping_ranger; depends on nothing.
package upr_pkg;

    localparam int TICKS_PER_MS    = 1000;
    localparam int TRIG_LOW_TICKS  = 2;
    localparam int TRIG_HIGH_TICKS = 5;

    localparam int PRE_W   = 10;
    localparam int CNT_W   = 16;
    localparam int RANGE_W = 14;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    // Range is 5 * duration / 29, kept as a running quotient and remainder.
    localparam int RANGE_MUL = 5;
    localparam int RANGE_DIV = 29;
    localparam int REM_W     = 5;

    localparam logic [CNT_W-1:0] TIMEOUT_RESET = 16'd35000;
    localparam logic [CNT_W-1:0] CNT_MAX       = '1;

    localparam logic [0:0] REG_MIN_INTERVAL = 1'b0;
    localparam logic [0:0] REG_ECHO_TIMEOUT = 1'b1;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_TLOW  = 3'd1;
    localparam logic [2:0] PH_THIGH = 3'd2;
    localparam logic [2:0] PH_WLOW  = 3'd3;
    localparam logic [2:0] PH_WHIGH = 3'd4;
    localparam logic [2:0] PH_ECHO  = 3'd5;

    typedef struct packed {
        logic [CNT_W-1:0] min_interval_ms;
        logic [CNT_W-1:0] echo_timeout_us;
    } t_cfg;

    typedef struct packed {
        logic               busy_res;
        logic               range_done;
        logic [RANGE_W-1:0] range_mm;
        logic               trigger_enable;
        logic               trigger_drive;
    } t_result;

endpackage

// ===== hdl/upr_cfg_regs.sv =====
// Configuration registers of the ping ranger behind an APB-style port.
// Depends on upr_pkg for the register map and the t_cfg struct.
module upr_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [upr_pkg::ADDR_W-1:0] paddr,
    input  logic [upr_pkg::DATA_W-1:0] pwdata,
    output logic [upr_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output upr_pkg::t_cfg              o_cfg
);

    upr_pkg::t_cfg r_cfg;
    logic          wr_en;
    logic [0:0]    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[2:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_interval_ms <= '0;
            r_cfg.echo_timeout_us <= upr_pkg::TIMEOUT_RESET;
        end else if (wr_en) begin
            case (reg_idx)
                upr_pkg::REG_MIN_INTERVAL: r_cfg.min_interval_ms <= pwdata[upr_pkg::CNT_W-1:0];
                upr_pkg::REG_ECHO_TIMEOUT: r_cfg.echo_timeout_us <= pwdata[upr_pkg::CNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            upr_pkg::REG_MIN_INTERVAL:
                prdata = {{(upr_pkg::DATA_W-upr_pkg::CNT_W){1'b0}}, r_cfg.min_interval_ms};
            upr_pkg::REG_ECHO_TIMEOUT:
                prdata = {{(upr_pkg::DATA_W-upr_pkg::CNT_W){1'b0}}, r_cfg.echo_timeout_us};
            default:
                prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/upr_core.sv =====
// Tick-by-tick sequencer of the ping ranger: trigger pulse, echo timing and range.
// Depends on upr_pkg; state advances once for each accepted tick.
module upr_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_req,
    input  logic              i_echo,
    input  upr_pkg::t_cfg     i_cfg,
    output upr_pkg::t_result  o_res
);

    logic [2:0]                  r_phase,  n_phase;
    logic [upr_pkg::CNT_W-1:0]   r_ph_cnt, n_ph_cnt;
    logic [upr_pkg::CNT_W-1:0]   r_echo,   n_echo;
    logic [upr_pkg::RANGE_W-1:0] r_quot,   n_quot;
    logic [upr_pkg::REM_W-1:0]   r_rem,    n_rem;
    logic [upr_pkg::PRE_W-1:0]   r_pre,    n_pre;
    logic [upr_pkg::CNT_W-1:0]   r_ms,     n_ms;
    logic [upr_pkg::RANGE_W-1:0] r_range,  n_range;

    logic                        finish;
    logic                        dur_zero;
    logic                        drive;
    logic                        en;
    logic                        done;
    logic [upr_pkg::REM_W:0]     rem_sum;

    always_comb begin
        n_phase  = r_phase;
        n_ph_cnt = r_ph_cnt;
        n_echo   = r_echo;
        n_quot   = r_quot;
        n_rem    = r_rem;
        n_pre    = r_pre;
        n_ms     = r_ms;
        n_range  = r_range;
        finish   = 1'b0;
        dur_zero = 1'b0;
        drive    = 1'b0;
        en       = 1'b0;
        done     = 1'b0;
        rem_sum  = {1'b0, r_rem} + (upr_pkg::REM_W+1)'(upr_pkg::RANGE_MUL);

        if (r_phase > upr_pkg::PH_ECHO) begin
            n_phase = upr_pkg::PH_IDLE;
        end

        if (n_phase == upr_pkg::PH_IDLE && i_req) begin
            if (r_ms >= i_cfg.min_interval_ms) begin
                n_phase  = upr_pkg::PH_TLOW;
                n_ph_cnt = '0;
            end else begin
                done = 1'b1;
            end
        end

        case (n_phase)
            upr_pkg::PH_TLOW: begin
                en       = 1'b1;
                n_ph_cnt = n_ph_cnt + 1'b1;
                if (n_ph_cnt >= upr_pkg::CNT_W'(upr_pkg::TRIG_LOW_TICKS)) begin
                    n_phase  = upr_pkg::PH_THIGH;
                    n_ph_cnt = '0;
                end
            end
            upr_pkg::PH_THIGH: begin
                en       = 1'b1;
                drive    = 1'b1;
                n_ph_cnt = n_ph_cnt + 1'b1;
                if (n_ph_cnt >= upr_pkg::CNT_W'(upr_pkg::TRIG_HIGH_TICKS)) begin
                    n_phase  = upr_pkg::PH_WLOW;
                    n_ph_cnt = '0;
                    n_echo   = '0;
                    n_quot   = '0;
                    n_rem    = '0;
                end
            end
            upr_pkg::PH_WLOW, upr_pkg::PH_WHIGH, upr_pkg::PH_ECHO: begin
                if (n_phase == upr_pkg::PH_WLOW) begin
                    if (!i_echo) begin
                        n_phase = upr_pkg::PH_WHIGH;
                    end
                end else if (n_phase == upr_pkg::PH_WHIGH) begin
                    if (i_echo) begin
                        n_phase = upr_pkg::PH_ECHO;
                        n_echo  = upr_pkg::CNT_W'(1);
                        n_quot  = '0;
                        n_rem   = upr_pkg::REM_W'(upr_pkg::RANGE_MUL);
                    end
                end else begin
                    if (i_echo) begin
                        if (r_echo != upr_pkg::CNT_MAX) begin
                            n_echo = r_echo + 1'b1;
                            if (rem_sum >= (upr_pkg::REM_W+1)'(upr_pkg::RANGE_DIV)) begin
                                n_rem  = upr_pkg::REM_W'(rem_sum -
                                         (upr_pkg::REM_W+1)'(upr_pkg::RANGE_DIV));
                                n_quot = r_quot + 1'b1;
                            end else begin
                                n_rem = rem_sum[upr_pkg::REM_W-1:0];
                            end
                        end
                    end else begin
                        finish = 1'b1;
                    end
                end
                n_ph_cnt = n_ph_cnt + 1'b1;
                if (!finish && n_ph_cnt >= i_cfg.echo_timeout_us) begin
                    finish   = 1'b1;
                    dur_zero = 1'b1;
                end
            end
            default: ;
        endcase

        if (finish) begin
            n_range  = dur_zero ? '0 : r_quot;
            done     = 1'b1;
            n_phase  = upr_pkg::PH_IDLE;
            n_ph_cnt = '0;
            n_ms     = '0;
            n_pre    = '0;
        end else begin
            n_pre = r_pre + 1'b1;
            if (n_pre >= upr_pkg::PRE_W'(upr_pkg::TICKS_PER_MS)) begin
                n_pre = '0;
                if (r_ms != upr_pkg::CNT_MAX) begin
                    n_ms = r_ms + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= upr_pkg::PH_IDLE;
            r_ph_cnt <= '0;
            r_echo   <= '0;
            r_quot   <= '0;
            r_rem    <= '0;
            r_pre    <= '0;
            r_ms     <= '0;
            r_range  <= '0;
        end else if (i_step) begin
            r_phase  <= n_phase;
            r_ph_cnt <= n_ph_cnt;
            r_echo   <= n_echo;
            r_quot   <= n_quot;
            r_rem    <= n_rem;
            r_pre    <= n_pre;
            r_ms     <= n_ms;
            r_range  <= n_range;
        end
    end

    assign o_res.trigger_drive  = drive;
    assign o_res.trigger_enable = en;
    assign o_res.range_mm       = n_range;
    assign o_res.range_done     = done;
    assign o_res.busy_res       = (n_phase != upr_pkg::PH_IDLE);

    // The running remainder of 5 * echo_ticks / 29 must stay below the divisor 29.
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem < upr_pkg::REM_W'(upr_pkg::RANGE_DIV))
        else $error("range remainder out of range");

    a_finish_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && finish) |=> (r_ms == '0 && r_pre == '0 && r_phase == upr_pkg::PH_IDLE))
        else $error("elapsed counters not cleared after measurement");

    a_prescale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pre < upr_pkg::PRE_W'(upr_pkg::TICKS_PER_MS))
        else $error("prescaler beyond one millisecond");

endmodule

// ===== hdl/ultrasonic_ping_ranger.sv =====
// Top level of the ultrasonic ping ranger: stream ports, APB registers, result register.
// Depends on upr_pkg, upr_cfg_regs and upr_core.
//
// Channel   Direction  Width  Contents
// s stream  in         8      tick: measure_request, echo_level
// m stream  out        24     result: drive, enable, range_mm, range_done, busy_res
// APB       in/out     32     min_interval_ms at 0x0, echo_timeout_us at 0x4
//
// One tick is accepted in every unstalled cycle; the result appears in the next cycle in the
// result register. The state update and range arithmetic sit in one combinational
// step, the range kept as a running quotient of the echo count.
// A stall on the master side holds the result register and stops ticks being taken.
// Reset is synchronous and returns the sequencer to idle with range zero.
module ultrasonic_ping_ranger (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    input  logic [7:0]                 i_s_tdata,   // [0] measure_request, [1] echo_level
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [23:0]                o_m_tdata,   // [0] trigger_drive, [1] trigger_enable,
                                                    // [15:2] range_mm, [16] range_done,
                                                    // [17] busy_res
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [upr_pkg::ADDR_W-1:0] paddr,
    input  logic [upr_pkg::DATA_W-1:0] pwdata,
    output logic [upr_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    upr_pkg::t_cfg    cfg;
    upr_pkg::t_result res;
    upr_pkg::t_result r_res;
    logic             r_valid;
    logic             step;

    upr_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign o_s_tready = !r_valid || i_m_tready;
    assign step       = i_s_tvalid && o_s_tready;

    upr_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (i_s_tdata[0]),
        .i_echo  (i_s_tdata[1]),
        .i_cfg   (cfg),
        .o_res   (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= res;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {6'b0, r_res};

    a_drive_enabled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_res.trigger_drive) |-> r_res.trigger_enable)
        else $error("pin driven high while not enabled");

    a_enable_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_res.trigger_enable) |-> r_res.busy_res)
        else $error("trigger active outside a measurement");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_res.range_done) |-> !r_res.busy_res)
        else $error("answer given while still measuring");

endmodule
